// ===== hw/rtl/lle_pkg.sv =====
// ----------------------------------------------------------------------------
// LED level envelope package
// Shared widths, constants, register indexes, sequencer states and the
// structures passed between the envelope modules.
// ----------------------------------------------------------------------------
package lle_pkg;

	// Field widths.
	localparam int unsigned LevelW   = 15;
	localparam int unsigned AttackW  = 18;
	localparam int unsigned DecayW   = 17;
	localparam int unsigned VolW     = 17;
	localparam int unsigned QuotW    = 16;
	localparam int unsigned LedW     = 8;
	localparam int unsigned CfgDataW = 18;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned MulAW    = 17;
	localparam int unsigned MulBW    = 18;
	localparam int unsigned ProdW    = MulAW + MulBW;

	// Volume constants in Q1.16.
	localparam logic [VolW-1:0] VOL_ONE  = 17'd65536;
	localparam logic [VolW-1:0] VOL_HUMP = 17'd655;

	// Register indexes on the configuration port.
	localparam logic [CfgIdxW-1:0] REG_WINDOW_LOW  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_WINDOW_HIGH = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_ATTACK_GAIN = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_DECAY_GAIN  = 2'd3;

	// Register reset values.
	localparam logic [LevelW-1:0]  RST_WINDOW_LOW  = 15'd17152;
	localparam logic [LevelW-1:0]  RST_WINDOW_HIGH = 15'd20480;
	localparam logic [AttackW-1:0] RST_ATTACK_GAIN = 18'd72427;
	localparam logic [DecayW-1:0]  RST_DECAY_GAIN  = 17'd64884;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_RANGE,
		S_DIVIDE,
		S_COMPARE,
		S_SCALE,
		S_DECAY,
		S_ATTACK,
		S_FINISH
	} state_t;

	// Configuration register set.
	typedef struct packed {
		logic [LevelW-1:0]  window_low_db;
		logic [LevelW-1:0]  window_high_db;
		logic [AttackW-1:0] attack_gain;
		logic [DecayW-1:0]  decay_gain;
	} cfg_t;

	// Result offered by the sequencer to the output register.
	typedef struct packed {
		logic            valid;
		logic [LedW-1:0] brightness;
	} res_t;

endpackage

// ===== hw/rtl/lle_div.sv =====
// ----------------------------------------------------------------------------
// LED level envelope divider
// Restoring radix-2 divider producing a 16-bit quotient of (a << 16) / d,
// one quotient bit per cycle. The caller guarantees a < d.
// ----------------------------------------------------------------------------
module lle_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lle_pkg::LevelW-1:0]     numer,
	input  logic [lle_pkg::LevelW-1:0]     denom,
	output logic                           done,
	output logic [lle_pkg::QuotW-1:0]      quot
);

	logic                        busy_q;
	logic                        done_q;
	logic [3:0]                  cnt_q;
	logic [lle_pkg::QuotW-1:0]   rem_q;
	logic [lle_pkg::QuotW-1:0]   quot_q;
	logic [lle_pkg::LevelW-1:0]  denom_q;
	logic [lle_pkg::QuotW:0]     trial;
	logic                        fits;

	// Trial subtraction of the divisor from the doubled remainder.
	always_comb begin
		trial = {rem_q, 1'b0} - {2'b00, denom_q};
		fits  = ~trial[lle_pkg::QuotW];
	end

	// Control: busy while the quotient is formed, then a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= {1'b0, numer};
			quot_q  <= '0;
			denom_q <= denom;
		end else if (busy_q) begin
			rem_q  <= fits ? trial[lle_pkg::QuotW-1:0] : {rem_q[lle_pkg::QuotW-2:0], 1'b0};
			quot_q <= {quot_q[lle_pkg::QuotW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== hw/rtl/lle_core.sv =====
// ----------------------------------------------------------------------------
// LED level envelope core
// Sequencer that maps a level to a target volume, by the divider inside the
// window, and applies decay or attack with one shared, registered multiplier.
// ----------------------------------------------------------------------------
module lle_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lle_pkg::cfg_t               cfg,
	input  logic                        start,
	input  logic [lle_pkg::LevelW-1:0]  level,
	input  logic                        res_ready,
	output logic                        idle,
	output lle_pkg::res_t               res
);

	lle_pkg::state_t                state_q, state_d;
	logic [lle_pkg::LevelW-1:0]     level_q;
	logic [lle_pkg::VolW-1:0]       held_q;
	logic [lle_pkg::VolW-1:0]       vol_q;
	logic                           decay_q;
	logic                           small_q;
	logic [lle_pkg::ProdW-1:0]      prod_q;

	logic                           div_start;
	logic                           div_done;
	logic [lle_pkg::QuotW-1:0]      div_quot;
	logic                           below_low;
	logic                           above_high;
	logic [18:0]                    p_x5;
	logic                           p_small;
	logic [lle_pkg::VolW-1:0]       gain_sat;
	logic [lle_pkg::VolW-1:0]       short_full;
	logic [lle_pkg::VolW-1:0]       short_eff;
	logic [lle_pkg::MulAW-1:0]      mul_a;
	logic [lle_pkg::MulBW-1:0]      mul_b;
	logic [18:0]                    prod_hi;
	logic                           rise_limited;
	logic [18:0]                    next_wide;
	logic [lle_pkg::VolW-1:0]       vol_new;
	logic [24:0]                    led_wide;

	lle_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (level_q - cfg.window_low_db),
		.denom  (cfg.window_high_db - cfg.window_low_db),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Window tests and decay terms.
	always_comb begin
		below_low  = level_q <= cfg.window_low_db;
		above_high = level_q >= cfg.window_high_db;
		p_x5       = {held_q, 2'b00} + {2'b00, held_q};
		p_small    = p_x5 < 19'd65536;
		gain_sat   = (cfg.decay_gain > lle_pkg::VOL_ONE) ? lle_pkg::VOL_ONE : cfg.decay_gain;
		short_full = lle_pkg::VOL_ONE - gain_sat;
		short_eff  = small_q ? prod_q[32:16] : short_full;
	end

	// New volume from the last product or the target, clamped to full scale.
	always_comb begin
		prod_hi      = prod_q[34:16];
		rise_limited = (prod_hi > {2'b00, held_q}) && (prod_hi > {2'b00, lle_pkg::VOL_HUMP});
		if (decay_q) begin
			next_wide = prod_hi;
		end else if (rise_limited && (prod_hi < {2'b00, vol_q})) begin
			next_wide = prod_hi;
		end else begin
			next_wide = {2'b00, vol_q};
		end
		vol_new = (next_wide > {2'b00, lle_pkg::VOL_ONE}) ? lle_pkg::VOL_ONE
			: next_wide[lle_pkg::VolW-1:0];
		led_wide = {vol_new, 8'h00} - {8'h00, vol_new};
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lle_pkg::S_IDLE: begin
				if (start) state_d = lle_pkg::S_RANGE;
			end
			lle_pkg::S_RANGE: begin
				if (below_low || above_high) state_d = lle_pkg::S_COMPARE;
				else state_d = lle_pkg::S_DIVIDE;
			end
			lle_pkg::S_DIVIDE: begin
				if (div_done) state_d = lle_pkg::S_COMPARE;
			end
			lle_pkg::S_COMPARE: begin
				if (vol_q < held_q) begin
					state_d = p_small ? lle_pkg::S_SCALE : lle_pkg::S_DECAY;
				end else begin
					state_d = lle_pkg::S_ATTACK;
				end
			end
			lle_pkg::S_SCALE:  state_d = lle_pkg::S_DECAY;
			lle_pkg::S_DECAY:  state_d = lle_pkg::S_FINISH;
			lle_pkg::S_ATTACK: state_d = lle_pkg::S_FINISH;
			lle_pkg::S_FINISH: begin
				if (res_ready) state_d = lle_pkg::S_IDLE;
			end
			default: state_d = lle_pkg::S_IDLE;
		endcase
	end

	// Output and operand selection per state.
	always_comb begin
		idle           = 1'b0;
		div_start      = 1'b0;
		res.valid      = 1'b0;
		res.brightness = led_wide[23:16];
		mul_a          = held_q;
		mul_b          = cfg.attack_gain;
		unique case (state_q)
			lle_pkg::S_IDLE:   idle = 1'b1;
			lle_pkg::S_RANGE:  div_start = ~(below_low | above_high);
			lle_pkg::S_SCALE: begin
				mul_a = short_full;
				mul_b = {2'b00, p_x5[15:0]};
			end
			lle_pkg::S_DECAY: begin
				mul_a = held_q;
				mul_b = {1'b0, lle_pkg::VOL_ONE - short_eff};
			end
			lle_pkg::S_FINISH: res.valid = 1'b1;
			default: ;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lle_pkg::S_IDLE;
			held_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == lle_pkg::S_FINISH && res_ready) held_q <= vol_new;
		end
	end

	// Datapath registers, including the shared multiplier's product, which is
	// held while a finished result waits for the output register.
	always_ff @(posedge clk) begin
		if (state_q != lle_pkg::S_FINISH) begin
			prod_q <= lle_pkg::ProdW'(mul_a) * lle_pkg::ProdW'(mul_b);
		end
		if (state_q == lle_pkg::S_IDLE && start) level_q <= level;
		if (state_q == lle_pkg::S_RANGE) begin
			vol_q <= above_high && !below_low ? lle_pkg::VOL_ONE : '0;
		end
		if (state_q == lle_pkg::S_DIVIDE && div_done) vol_q <= {1'b0, div_quot};
		if (state_q == lle_pkg::S_COMPARE) begin
			decay_q <= vol_q < held_q;
			small_q <= p_small;
		end
	end

endmodule

// ===== hw/rtl/led_level_envelope.sv =====
// ----------------------------------------------------------------------------
// LED level envelope
// Attack/decay envelope follower turning a dB level into an LED drive value.
// Each level passes the sequencer states RANGE, DIVIDE (only when the level
// falls inside the window, in the serial divider), COMPARE, SCALE (only for a
// decay from a low volume), DECAY or ATTACK, and FINISH, which holds while
// the output is stalled. One item at a time: the next transfer is taken the
// cycle after the result has left the sequencer.
// Reset clears the held volume and loads the default window and gains.
// ----------------------------------------------------------------------------
module led_level_envelope (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lle_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [lle_pkg::CfgDataW-1:0]  cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lle_pkg::LevelW-1:0]    level_db,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [lle_pkg::LedW-1:0]      led_brightness
);

	lle_pkg::cfg_t              cfg_q;
	lle_pkg::res_t              res;
	logic                       core_idle;
	logic                       out_free;
	logic                       out_valid_q;
	logic [lle_pkg::LedW-1:0]   led_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_low_db  <= lle_pkg::RST_WINDOW_LOW;
			cfg_q.window_high_db <= lle_pkg::RST_WINDOW_HIGH;
			cfg_q.attack_gain    <= lle_pkg::RST_ATTACK_GAIN;
			cfg_q.decay_gain     <= lle_pkg::RST_DECAY_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lle_pkg::REG_WINDOW_LOW:  cfg_q.window_low_db  <= cfg_wdata[lle_pkg::LevelW-1:0];
				lle_pkg::REG_WINDOW_HIGH: cfg_q.window_high_db <= cfg_wdata[lle_pkg::LevelW-1:0];
				lle_pkg::REG_ATTACK_GAIN: cfg_q.attack_gain    <= cfg_wdata;
				lle_pkg::REG_DECAY_GAIN:  cfg_q.decay_gain     <= cfg_wdata[lle_pkg::DecayW-1:0];
				default: ;
			endcase
		end
	end

	// Input transfers are taken only while the sequencer is idle.
	assign in_stall = ~core_idle;
	assign out_free = ~out_valid_q | ~out_stall;

	lle_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (in_valid & core_idle),
		.level     (level_db),
		.res_ready (out_free),
		.idle      (core_idle),
		.res       (res)
	);

	// Output register holding a finished result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) led_q <= res.brightness;
	end

	assign out_valid      = out_valid_q;
	assign led_brightness = led_q;

endmodule

// ===== test/led_level_envelope_check.sv =====
// ----------------------------------------------------------------------------
// LED level envelope checker
// Watches the configuration port and both channels of the envelope block.
// It keeps its own copy of the registers and of the held volume, predicts the
// LED drive for every accepted level and compares it with each result.
// ----------------------------------------------------------------------------
module led_level_envelope_check
	import lle_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [LevelW-1:0]   level_db,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [LedW-1:0]     led_brightness,
	output int                  fail_count,
	output int                  pending
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned ONE_Q16  = VOL_ONE;
	localparam longint unsigned HUMP_Q16 = VOL_HUMP;
	localparam longint unsigned LED_MAX  = 255;

	// Shadow registers and envelope state.
	logic [LevelW-1:0]  win_low;
	logic [LevelW-1:0]  win_high;
	logic [AttackW-1:0] rise_gain;
	logic [DecayW-1:0]  fall_gain;
	logic [VolW-1:0]    held_vol;

	logic [LedW-1:0] brightness_due [$];
	int              errs;

	// Works out the next volume for one level, holds it and returns the drive.
	function automatic logic [LedW-1:0] track_level(input logic [LevelW-1:0] level);
		longint unsigned lv, lo, hi, prev, tgt, g, s, m, nxt;
		lv = level;
		lo = win_low;
		hi = win_high;
		prev = (held_vol > VOL_ONE) ? ONE_Q16 : held_vol;

		// The low edge is tested first, so an inverted window never divides.
		if (lv <= lo)
			tgt = 0;
		else if (lv >= hi)
			tgt = ONE_Q16;
		else
			tgt = ((lv - lo) << 16) / (hi - lo);

		if (tgt < prev) begin
			// Falling: the shortfall shrinks linearly while the volume is below 0.2.
			g = fall_gain;
			if (g > ONE_Q16)
				g = ONE_Q16;
			s = ONE_Q16 - g;
			if (prev * 5 < ONE_Q16)
				s = (s * prev * 5) >> 16;
			nxt = (prev * (ONE_Q16 - s)) >> 16;
		end else begin
			// Rising: limited by the attack gain unless the limit is too small to matter.
			m = (prev * rise_gain) >> 16;
			if (m > prev && m > HUMP_Q16)
				nxt = (tgt < m) ? tgt : m;
			else
				nxt = tgt;
		end
		if (nxt > ONE_Q16)
			nxt = ONE_Q16;

		held_vol = nxt[VolW-1:0];
		return LedW'((nxt * LED_MAX) >> 16);
	endfunction

	// All channel activity is sampled at the rising edge, before the block updates.
	always @(posedge clk or negedge arst_n) begin
		logic [LedW-1:0] due;
		if (!arst_n) begin
			win_low   = RST_WINDOW_LOW;
			win_high  = RST_WINDOW_HIGH;
			rise_gain = RST_ATTACK_GAIN;
			fall_gain = RST_DECAY_GAIN;
			held_vol  = '0;
			brightness_due.delete();
			errs = 0;
		end else begin
			// Results are compared before a new level is queued behind them.
			if (out_valid && !out_stall) begin
				if (brightness_due.size() == 0) begin
					$error("led_brightness: transfer with no expectation, actual %0d",
						led_brightness);
					errs++;
				end else begin
					due = brightness_due.pop_front();
					if (led_brightness !== due) begin
						$error("led_brightness mismatch: expected %0d, actual %0d",
							due, led_brightness);
						errs++;
					end
				end
			end
			if (in_valid && !in_stall)
				brightness_due.push_back(track_level(level_db));
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_LOW:  win_low   = cfg_wdata[LevelW-1:0];
					REG_WINDOW_HIGH: win_high  = cfg_wdata[LevelW-1:0];
					REG_ATTACK_GAIN: rise_gain = cfg_wdata[AttackW-1:0];
					REG_DECAY_GAIN:  fall_gain = cfg_wdata[DecayW-1:0];
					default: ;
				endcase
			end
		end
		fail_count <= errs;
		pending    <= brightness_due.size();
	end

endmodule

// ===== test/led_level_envelope_tb.sv =====
// ----------------------------------------------------------------------------
// LED level envelope testbench
// Drives dB levels into the envelope block under a series of window and gain
// settings, with random gaps and output stalls, and leaves the checking to
// the checker instantiated beside the block. Gives the final verdict.
// ----------------------------------------------------------------------------
module led_level_envelope_tb;

	import lle_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = REG_WINDOW_LOW;
	logic [CfgDataW-1:0] cfg_wdata = '0;
	logic                in_valid  = 1'b0;
	logic [LevelW-1:0]   level_db  = '0;
	logic                out_stall = 1'b0;
	logic                in_stall;
	logic                out_valid;
	logic [LedW-1:0]     led_brightness;

	// When set, neither side idles.
	logic steady = 1'b0;

	int fail_count;
	int pending;
	int win_lo = int'(RST_WINDOW_LOW);
	int win_hi = int'(RST_WINDOW_HIGH);
	int last_level = 0;
	int n_levels = 0;
	int n_settings = 1;

	led_level_envelope dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.level_db       (level_db),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.led_brightness (led_brightness)
	);

	led_level_envelope_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.level_db       (level_db),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.led_brightness (led_brightness),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always #5 clk = ~clk;

	// The receiving side stalls at random unless the run is in a steady stretch.
	always @(posedge clk) begin
		out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 35);
	end

	// Offers one level, after a random number of idle cycles, until it transfers.
	task automatic offer_level(input int lvl);
		while (!steady && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		level_db <= lvl[LevelW-1:0];
		do
			@(posedge clk);
		while (in_stall);
		last_level = lvl;
		n_levels++;
	endtask

	// Stops offering levels and waits until every result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Writes all four registers on successive edges while the block is idle.
	task automatic load_regs(input int lo, input int hi, input int atk, input int dcy);
		logic [CfgIdxW-1:0]  idx [4];
		logic [CfgDataW-1:0] val [4];
		idx = '{REG_WINDOW_LOW, REG_WINDOW_HIGH, REG_ATTACK_GAIN, REG_DECAY_GAIN};
		val = '{CfgDataW'(lo), CfgDataW'(hi), CfgDataW'(atk), CfgDataW'(dcy)};
		wait_drained();
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		win_lo = lo & 32'h7FFF;
		win_hi = hi & 32'h7FFF;
		n_settings++;
	endtask

	// Picks a level: mostly near the window edges, inside it or drifting, with
	// some silence and some fully random values.
	function automatic int pick_level();
		int r, lvl, wlo, whi;
		r = $urandom_range(0, 99);
		wlo = (win_lo < win_hi) ? win_lo : win_hi;
		whi = (win_lo < win_hi) ? win_hi : win_lo;
		if (r < 15)
			lvl = $urandom_range(0, 32767);
		else if (r < 35)
			lvl = last_level + $urandom_range(0, 600) - 300;
		else if (r < 50)
			lvl = (r[0] ? wlo : whi) + $urandom_range(0, 4) - 2;
		else if (r < 58)
			lvl = 0;
		else
			lvl = $urandom_range((wlo > 200) ? wlo - 200 : 0,
				(whi < 32567) ? whi + 200 : 32767);
		if (lvl < 0)
			lvl = 0;
		if (lvl > 32767)
			lvl = 32767;
		return lvl;
	endfunction

	// Stimulus and verdict.
	initial begin
		int lv_q[$];
		int pick, lo, hi, atk, dcy;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default registers: both window edges, a level just inside each, the midpoint and full swings.
		lv_q = '{0, 32767, 17152, 17153, 20479, 20480, 18816, 32767, 32767, 0};
		foreach (lv_q[i])
			offer_level(lv_q[i]);

		// Fast halving decay down through the low-volume region, then doubling attack.
		load_regs(1000, 9000, 131072, 32768);
		lv_q = '{9000, 0, 0, 0, 0, 0, 1100, 9000, 9000, 5000, 999};
		foreach (lv_q[i])
			offer_level(lv_q[i]);

		// Attack gain below one and decay gain saturated, on an inverted window.
		load_regs(20000, 10000, 0, 131071);
		lv_q = '{20000, 20001, 32767, 0};
		foreach (lv_q[i])
			offer_level(lv_q[i]);

		// Empty window, largest attack gain and full decay.
		load_regs(5000, 5000, 262143, 0);
		lv_q = '{5000, 5001, 0, 32767};
		foreach (lv_q[i])
			offer_level(lv_q[i]);

		// Random phases, each under a fresh setting; the fourth runs without idling.
		for (int ph = 0; ph < 8; ph++) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: begin lo = 0; hi = 32767; end
				1: begin lo = $urandom_range(16384, 32767); hi = $urandom_range(0, 16383); end
				2: begin lo = $urandom_range(0, 32767); hi = lo; end
				default: begin
					lo = $urandom_range(0, 30000);
					hi = lo + $urandom_range(16, 2767);
				end
			endcase
			pick = $urandom_range(0, 9);
			case (pick)
				0: atk = 65536;
				1: atk = 262143;
				2: atk = $urandom_range(0, 65535);
				default: atk = $urandom_range(65537, 140000);
			endcase
			pick = $urandom_range(0, 9);
			case (pick)
				0: dcy = 0;
				1: dcy = 65536;
				2: dcy = $urandom_range(65537, 131071);
				3: dcy = $urandom_range(0, 65536);
				default: dcy = $urandom_range(55000, 65535);
			endcase
			// Unused upper data bits are set at random on the window writes.
			load_regs(lo + ($urandom_range(0, 7) << 15), hi + ($urandom_range(0, 7) << 15),
				atk, dcy);
			steady <= (ph == 3);
			for (int k = 0; k < 125; k++)
				offer_level(pick_level());
		end
		steady <= 1'b0;

		wait_drained();
		repeat (30) @(posedge clk);

		$display("Sent %0d level transfers under %0d register settings,", n_levels, n_settings);
		$display("including inverted and empty windows and out-of-range gains.");
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Guard against a hang.
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/lle_pkg.sv
hw/rtl/lle_div.sv
hw/rtl/lle_core.sv
hw/rtl/led_level_envelope.sv
test/led_level_envelope_check.sv
test/led_level_envelope_tb.sv
